// ===== rtl/tcbd_pkg.sv =====
// Shared types and constants of the tap code button decoder.
`timescale 1ns / 1ps

package tcbd_pkg;

    localparam int unsigned SQUARE_SIDE = 5;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LETTERS = 2'd2;

    localparam logic [15:0] PRESS_TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] WORD_TIMEOUT_RESET = 16'd2000;
    localparam logic [7:0] MAX_LETTERS_RESET = 8'd32;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic [15:0] press_timeout_ms;
        logic [15:0] word_timeout_ms;
        logic [7:0]  max_letters;
    } cfg_t;

    typedef struct packed {
        logic [2:0] row_pending;
        logic       word_done;
        logic [7:0] letters_in_word;
        logic [7:0] letter_position;
        logic [4:0] letter_cell;
        logic       letter_valid;
    } result_t;

endpackage

// ===== rtl/tcbd_cfg_regs.sv =====
// Configuration registers of the tap code button decoder.
`timescale 1ns / 1ps

module tcbd_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcbd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tcbd_pkg::cfg_t                     cfg
);

    tcbd_pkg::cfg_t cfg_reg;
    tcbd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tcbd_pkg::CFG_PRESS_TIMEOUT: cfg_next.press_timeout_ms = cfg_data;
                tcbd_pkg::CFG_WORD_TIMEOUT:  cfg_next.word_timeout_ms = cfg_data;
                tcbd_pkg::CFG_MAX_LETTERS:   cfg_next.max_letters = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_timeout_ms <= tcbd_pkg::PRESS_TIMEOUT_RESET;
            cfg_reg.word_timeout_ms <= tcbd_pkg::WORD_TIMEOUT_RESET;
            cfg_reg.max_letters <= tcbd_pkg::MAX_LETTERS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/tcbd_core.sv =====
// Decoder state and the single-pass update for one tick or clear item.
`timescale 1ns / 1ps

module tcbd_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               mode,
    input  logic               button_down,
    input  tcbd_pkg::cfg_t     cfg,
    output tcbd_pkg::result_t  result
);

    logic        held_reg;
    logic        held_next;
    logic [2:0]  press_count_reg;
    logic [2:0]  press_count_next;
    logic [2:0]  row_sel_reg;
    logic [2:0]  row_sel_next;
    logic [2:0]  column_sel_reg;
    logic [2:0]  column_sel_next;
    logic [15:0] idle_ticks_reg;
    logic [15:0] idle_ticks_next;
    logic [7:0]  letter_count_reg;
    logic [7:0]  letter_count_next;
    logic        finished_reg;
    logic        finished_next;

    logic [2:0]  row_m1;
    logic [2:0]  column_m1;
    logic [5:0]  cell_sum;

    always_comb
    begin
        held_next = held_reg;
        press_count_next = press_count_reg;
        row_sel_next = row_sel_reg;
        column_sel_next = column_sel_reg;
        idle_ticks_next = idle_ticks_reg;
        letter_count_next = letter_count_reg;
        finished_next = finished_reg;
        row_m1 = 3'd0;
        column_m1 = 3'd0;
        cell_sum = 6'd0;
        result = '0;

        if (mode == tcbd_pkg::MODE_CLEAR)
        begin
            row_sel_next = 3'd0;
            column_sel_next = 3'd0;
            finished_next = 1'b0;
            letter_count_next = 8'd0;
        end
        else
        begin
            if (idle_ticks_reg != tcbd_pkg::IDLE_MAX)
            begin
                idle_ticks_next = idle_ticks_reg + 16'd1;
            end

            if (button_down && !held_reg)
            begin
                held_next = 1'b1;
                idle_ticks_next = 16'd0;
                press_count_next = press_count_reg + 3'd1;
            end
            else if (!button_down && held_reg)
            begin
                held_next = 1'b0;
            end

            if ((press_count_next != 3'd0 && idle_ticks_next > cfg.press_timeout_ms) ||
                press_count_next == 3'(tcbd_pkg::SQUARE_SIDE))
            begin
                if (row_sel_next == 3'd0)
                begin
                    row_sel_next = press_count_next;
                    press_count_next = 3'd0;
                    idle_ticks_next = 16'd0;
                end
                else if (column_sel_next == 3'd0)
                begin
                    column_sel_next = press_count_next;
                    press_count_next = 3'd0;
                    idle_ticks_next = 16'd0;
                end

                if (row_sel_next != 3'd0 && column_sel_next != 3'd0)
                begin
                    if (letter_count_reg < cfg.max_letters)
                    begin
                        row_m1 = row_sel_next - 3'd1;
                        column_m1 = column_sel_next - 3'd1;
                        cell_sum = 6'(row_m1) * 6'(tcbd_pkg::SQUARE_SIDE) + 6'(column_m1);
                        result.letter_valid = 1'b1;
                        result.letter_cell = cell_sum[4:0];
                        result.letter_position = letter_count_reg;
                        letter_count_next = letter_count_reg + 8'd1;
                    end
                    row_sel_next = 3'd0;
                    column_sel_next = 3'd0;
                end
            end

            if (press_count_next == 3'd0 && idle_ticks_next > cfg.word_timeout_ms)
            begin
                if (row_sel_next != 3'd0)
                begin
                    row_sel_next = 3'd0;
                end
                else if (letter_count_next != 8'd0 && !finished_next)
                begin
                    finished_next = 1'b1;
                end
            end
        end

        result.letters_in_word = letter_count_next;
        result.word_done = finished_next;
        result.row_pending = row_sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            press_count_reg <= 3'd0;
            row_sel_reg <= 3'd0;
            column_sel_reg <= 3'd0;
            idle_ticks_reg <= 16'd0;
            letter_count_reg <= 8'd0;
            finished_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            press_count_reg <= press_count_next;
            row_sel_reg <= row_sel_next;
            column_sel_reg <= column_sel_next;
            idle_ticks_reg <= idle_ticks_next;
            letter_count_reg <= letter_count_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== rtl/tcbd_skid.sv =====
// Output register with a skid stage for result items.
`timescale 1ns / 1ps

module tcbd_skid
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcbd_pkg::result_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tcbd_pkg::result_t  out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    tcbd_pkg::result_t out_data_reg;
    tcbd_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    tcbd_pkg::result_t skid_data_reg;
    tcbd_pkg::result_t skid_data_next;
    logic              push;
    logic              pop;

    assign in_ready = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign push = in_valid && in_ready;
    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next = in_data;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/tap_code_button_decoder_top.sv =====
// Top level of the tap code button decoder.
`timescale 1ns / 1ps

// Each input item is either a one-millisecond tick carrying the debounced
// button level or a command that clears the word; every item gives exactly
// one result item.
// The input channel carries the kind of item in s_axis_tuser and the button
// level in s_axis_tdata. The output channel flags a decoded letter in
// m_axis_tuser and carries the cell index, letter position, letter count,
// word-finished flag and pending row in m_axis_tdata.
// The configuration channel writes the press timeout, the word timeout and
// the letter limit; it is always ready and should only be used while idle.
// An item is processed in the cycle it is accepted, and its result is
// registered in the output stage. One item is accepted every cycle while
// the skid stage is empty. When the receiver stalls, one further item is
// held in a skid stage and s_axis_tready then drops until the output drains.
// Reset clears all decoder state, loads the register defaults (500, 2000
// and 32) and empties the output stages.
module tap_code_button_decoder_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // button_down
    input  logic                               s_axis_tuser,   // mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // letter_cell, letter_position, letters_in_word, word_done, row_pending
    output logic [31:0]                        m_axis_tdata,
    output logic                               m_axis_tuser,   // letter_valid
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tcbd_pkg::cfg_t    cfg;
    tcbd_pkg::result_t core_result;
    tcbd_pkg::result_t out_result;
    logic              accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    tcbd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcbd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (s_axis_tuser),
        .button_down (s_axis_tdata[0]),
        .cfg         (cfg),
        .result      (core_result)
    );

    tcbd_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (core_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tuser = out_result.letter_valid;
    assign m_axis_tdata = {7'd0, out_result.row_pending, out_result.word_done,
                           out_result.letters_in_word, out_result.letter_position,
                           out_result.letter_cell};

endmodule

// ===== test/tap_code_button_decoder_top_test.sv =====
// Self-checking testbench of the tap code button decoder, with a built-in predictor.
`timescale 1ns / 1ps

module tap_code_button_decoder_top_test;

    localparam logic [tcbd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [31:0]                      m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tcbd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tcbd_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Predicted register contents and decoder state.
    logic [15:0] press_timeout = tcbd_pkg::PRESS_TIMEOUT_RESET;
    logic [15:0] word_timeout = tcbd_pkg::WORD_TIMEOUT_RESET;
    logic [7:0]  letter_limit = tcbd_pkg::MAX_LETTERS_RESET;
    logic        held = 1'b0;
    logic [2:0]  press_count = 3'd0;
    logic [2:0]  row_sel = 3'd0;
    logic [2:0]  column_sel = 3'd0;
    logic [15:0] idle_ticks = 16'd0;
    logic [7:0]  letter_count = 8'd0;
    logic        word_finished = 1'b0;

    tcbd_pkg::result_t results_due[$];

    int  errors = 0;
    int  items_sent = 0;
    int  clears_sent = 0;
    int  writes_done = 0;
    int  results_checked = 0;
    int  letters_checked = 0;
    int  finished_results = 0;
    int  receiver_hold = 0;
    bit  steady = 1'b0;

    tap_code_button_decoder_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d result items still expected.", results_due.size());
        $display("** tap_code_button_decoder_top: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic decode_item(input logic mode, input logic down);
        tcbd_pkg::result_t r;
        r = '0;
        if (mode == tcbd_pkg::MODE_CLEAR)
        begin
            row_sel = 3'd0;
            column_sel = 3'd0;
            word_finished = 1'b0;
            letter_count = 8'd0;
        end
        else
        begin
            if (idle_ticks != tcbd_pkg::IDLE_MAX)
                idle_ticks = idle_ticks + 16'd1;
            if (down && !held)
            begin
                held = 1'b1;
                idle_ticks = 16'd0;
                press_count = press_count + 3'd1;
            end
            else if (!down && held)
                held = 1'b0;

            if ((press_count != 3'd0 && idle_ticks > press_timeout) ||
                press_count == 3'(tcbd_pkg::SQUARE_SIDE))
            begin
                if (row_sel == 3'd0)
                begin
                    row_sel = press_count;
                    press_count = 3'd0;
                    idle_ticks = 16'd0;
                end
                else if (column_sel == 3'd0)
                begin
                    column_sel = press_count;
                    press_count = 3'd0;
                    idle_ticks = 16'd0;
                end
                if (row_sel != 3'd0 && column_sel != 3'd0)
                begin
                    if (letter_count < letter_limit)
                    begin
                        r.letter_valid = 1'b1;
                        r.letter_cell = 5'((row_sel - 1) * tcbd_pkg::SQUARE_SIDE +
                                           (column_sel - 1));
                        r.letter_position = letter_count;
                        letter_count = letter_count + 8'd1;
                    end
                    row_sel = 3'd0;
                    column_sel = 3'd0;
                end
            end

            if (press_count == 3'd0 && idle_ticks > word_timeout)
            begin
                if (row_sel != 3'd0)
                    row_sel = 3'd0;
                else if (letter_count != 8'd0 && !word_finished)
                    word_finished = 1'b1;
            end
        end
        r.letters_in_word = letter_count;
        r.word_done = word_finished;
        r.row_pending = row_sel;
        results_due.push_back(r);
    endtask

    task automatic send_item(input logic mode, input logic down);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {7'd0, down};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (mode == tcbd_pkg::MODE_CLEAR)
            clears_sent++;
        decode_item(mode, down);
    endtask

    task automatic send_idle(input int ticks);
        repeat (ticks) send_item(tcbd_pkg::MODE_TICK, 1'b0);
    endtask

    task automatic tap_presses(input int presses, input int up_ticks);
        repeat (presses)
        begin
            send_item(tcbd_pkg::MODE_TICK, 1'b1);
            send_idle(up_ticks);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tcbd_pkg::CFG_INDEX_W-1:0] index,
                             input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        writes_done++;
        case (index)
            tcbd_pkg::CFG_PRESS_TIMEOUT: press_timeout = value;
            tcbd_pkg::CFG_WORD_TIMEOUT:  word_timeout = value;
            tcbd_pkg::CFG_MAX_LETTERS:   letter_limit = value[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] press_ms, input logic [15:0] word_ms,
                             input logic [7:0] letters, input bit with_unused);
        logic [7:0] upper;
        upper = 8'($urandom);
        wait_idle();
        write_reg(tcbd_pkg::CFG_PRESS_TIMEOUT, press_ms);
        write_reg(tcbd_pkg::CFG_WORD_TIMEOUT, word_ms);
        write_reg(tcbd_pkg::CFG_MAX_LETTERS, {upper, letters});
        if (with_unused)
            write_reg(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_activity(input int count);
        int target;
        int r;
        int up_max;
        int settle;
        target = items_sent + count;
        up_max = (press_timeout > 3) ? 3 : ((press_timeout == 0) ? 1 : press_timeout);
        settle = (press_timeout > 7) ? 8 : press_timeout + 1;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                tap_presses($urandom_range(1, 5), $urandom_range(1, up_max));
                send_idle(settle);
                tap_presses($urandom_range(1, 5), $urandom_range(1, up_max));
                send_idle(settle);
            end
            else if (r < 72)
                repeat ($urandom_range(1, 8))
                    send_item(tcbd_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
            else if (r < 80)
                send_item(tcbd_pkg::MODE_CLEAR, 1'($urandom_range(0, 1)));
            else
                send_idle((word_timeout > 14) ? 16 : word_timeout + 2);
        end
    endtask

    // Five presses fix a row at once, whatever the timeouts.
    task automatic test_reset_defaults();
        tap_presses(5, 1);
        send_item(tcbd_pkg::MODE_CLEAR, 1'b0);
    endtask

    // Row and column by press timeout, a full word, row cancel and word finish.
    task automatic test_word_rules();
        configure(16'd1, 16'd3, 8'd1, 1'b0);
        tap_presses(1, 1);
        send_idle(1);
        tap_presses(2, 1);
        send_idle(1);
        tap_presses(3, 1);
        send_idle(5);
        tap_presses(1, 1);
        send_idle(1);
        tap_presses(1, 1);
        send_idle(5);
        send_item(tcbd_pkg::MODE_CLEAR, 1'b1);
        send_item(tcbd_pkg::MODE_TICK, 1'b0);
    endtask

    // Register values at and beyond their limits, and an unknown register index.
    task automatic test_register_limits();
        configure(16'd0, 16'd65535, 8'd0, 1'b1);
        tap_presses(1, 1);
        tap_presses(1, 1);
        configure(16'd65535, 16'd0, 8'd255, 1'b0);
        tap_presses(5, 1);
        configure(16'd65534, 16'd65534, 8'd255, 1'b0);
        tap_presses(5, 1);
        tap_presses(5, 1);
    endtask

    // The receiver holds off while the sender streams, so the input must stall.
    task automatic test_back_pressure();
        configure(16'd2, 16'd9, 8'd255, 1'b0);
        steady = 1'b1;
        receiver_hold = 60;
        random_activity(40);
        steady = 1'b0;
    endtask

    task automatic test_random_words();
        int start;
        int r;
        logic [15:0] press_ms;
        logic [15:0] word_ms;
        logic [7:0]  letters;
        start = items_sent;
        while (items_sent - start < 300)
        begin
            r = $urandom_range(0, 9);
            press_ms = (r == 0) ? 16'd65534 : 16'($urandom_range(1, 5));
            if (r == 1)
                word_ms = 16'd65534;
            else if (r == 0)
                word_ms = 16'($urandom_range(2, 12));
            else
                word_ms = press_ms + 16'($urandom_range(2, 10));
            letters = (r == 2) ? 8'd255 : 8'($urandom_range(1, 6));
            configure(press_ms, word_ms, letters, r == 3);
            steady = ($urandom_range(0, 3) == 0);
            random_activity($urandom_range(30, 70));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = tcbd_pkg::MODE_TICK;
        cfg_valid = 1'b0;
        cfg_index = tcbd_pkg::CFG_PRESS_TIMEOUT;
        cfg_data = 16'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_word_rules();
        test_register_limits();
        test_back_pressure();
        test_random_words();
        wait_idle();

        $display("Sent %0d input items (%0d clears) and %0d register writes; checked %0d results.",
                 items_sent, clears_sent, writes_done, results_checked);
        $display("Decoded %0d letters; %0d results carried the word-finished flag.",
                 letters_checked, finished_results);
        if (errors == 0)
            $display("** tap_code_button_decoder_top: PASSED **");
        else
            $display("** tap_code_button_decoder_top: FAILED **");
        $finish;
    end

    initial
    begin : receiver
        int stall;
        int hold_len;
        stall = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (receiver_hold > 0)
            begin
                hold_len = receiver_hold;
                receiver_hold = 0;
                stall = 0;
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 20)
                    stall = pick_gap();
            end
        end
    end

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        tcbd_pkg::result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = results_due.pop_front();
                results_checked++;
                if (want.letter_valid)
                    letters_checked++;
                if (want.word_done)
                    finished_results++;
                check_field("letter_valid", want.letter_valid, m_axis_tuser);
                check_field("letter_cell", want.letter_cell, m_axis_tdata[4:0]);
                check_field("letter_position", want.letter_position, m_axis_tdata[12:5]);
                check_field("letters_in_word", want.letters_in_word, m_axis_tdata[20:13]);
                check_field("word_done", want.word_done, m_axis_tdata[21]);
                check_field("row_pending", want.row_pending, m_axis_tdata[24:22]);
                check_field("tdata padding", 0, m_axis_tdata[31:25]);
            end
        end
    end

endmodule
